// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bbfb_pkg.sv =====
// ----------------------------------------------------------------------------
// bbfb_pkg
// types, constants and helper functions of the baseband frame builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbfb_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int HIDX_W       = 4;
    localparam int FIELD_W      = 13;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [14:0] PRBS_SEED     = 15'h4A80;
    localparam logic [7:0]  FIRST_PKT_CRC = 8'h47;
    localparam logic [7:0]  CRC_POLY_REF  = 8'h8C;
    localparam logic [15:0] SYNCD_NONE    = 16'hFFFF;

    // header byte positions
    localparam logic [HIDX_W-1:0] H_MATYPE_HI = 4'd0;
    localparam logic [HIDX_W-1:0] H_MATYPE_LO = 4'd1;
    localparam logic [HIDX_W-1:0] H_UPL_HI    = 4'd2;
    localparam logic [HIDX_W-1:0] H_UPL_LO    = 4'd3;
    localparam logic [HIDX_W-1:0] H_DFL_HI    = 4'd4;
    localparam logic [HIDX_W-1:0] H_DFL_LO    = 4'd5;
    localparam logic [HIDX_W-1:0] H_SYNC      = 4'd6;
    localparam logic [HIDX_W-1:0] H_SYNCD_HI  = 4'd7;
    localparam logic [HIDX_W-1:0] H_SYNCD_LO  = 4'd8;
    localparam logic [HIDX_W-1:0] H_CRC       = 4'd9;
    localparam logic [HIDX_W-1:0] H_DONE      = 4'd10;

    typedef enum logic [2:0] {
        REG_MATYPE = 3'd0,
        REG_UPL    = 3'd1,
        REG_DFB    = 3'd2,
        REG_SYNC   = 3'd3,
        REG_SCRAM  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        mode_type_word;
        logic [15:0]        packet_length_bits;
        logic [FIELD_W-1:0] data_field_bytes;
        logic [7:0]         sync_byte_value;
        logic               scramble_enable;
    } t_cfg;

    // one accepted stream byte after packet processing
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] syncd;
    } t_job;

    typedef struct packed {
        logic [7:0]  scr;
        logic [14:0] state;
    } t_prbs_out;

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

    // eight steps of 1+x^14+x^15, msb first
    function automatic t_prbs_out prbs_byte(input logic [14:0] st);
        t_prbs_out r;
        logic      bit_v;
        r.state = st;
        r.scr   = '0;
        for (int i = 0; i < 8; i++) begin
            bit_v   = r.state[0] ^ r.state[1];
            r.scr   = {r.scr[6:0], bit_v};
            r.state = {bit_v, r.state[14:1]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bbfb_cfg.sv =====
// ----------------------------------------------------------------------------
// bbfb_cfg
// apb register file holding the frame header and scrambler settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbfb_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbfb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bbfb_pkg::DATA_W-1:0] pwdata,
    output logic      [bbfb_pkg::DATA_W-1:0] prdata,
    output bbfb_pkg::t_cfg                   o_cfg
);
    import bbfb_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[4:2]);
    assign w_wr  = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_type_word     <= 16'd65500;
            r_cfg.packet_length_bits <= 16'd1504;
            r_cfg.data_field_bytes   <= 13'd1991;
            r_cfg.sync_byte_value    <= 8'd71;
            r_cfg.scramble_enable    <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                REG_MATYPE: r_cfg.mode_type_word     <= pwdata[15:0];
                REG_UPL:    r_cfg.packet_length_bits <= pwdata[15:0];
                REG_DFB:    r_cfg.data_field_bytes   <= pwdata[FIELD_W-1:0];
                REG_SYNC:   r_cfg.sync_byte_value    <= pwdata[7:0];
                REG_SCRAM:  r_cfg.scramble_enable    <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MATYPE: prdata = {16'd0, r_cfg.mode_type_word};
            REG_UPL:    prdata = {16'd0, r_cfg.packet_length_bits};
            REG_DFB:    prdata = {{(DATA_W-FIELD_W){1'b0}}, r_cfg.data_field_bytes};
            REG_SYNC:   prdata = {24'd0, r_cfg.sync_byte_value};
            REG_SCRAM:  prdata = {31'd0, r_cfg.scramble_enable};
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbfb_front.sv =====
// ----------------------------------------------------------------------------
// bbfb_front
// packet counting, sync byte crc replacement and frame position tracking
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbfb_front #(
    parameter int PACKET_BYTES = 188
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  bbfb_pkg::t_cfg      i_cfg,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_byte,
    output logic                o_ready,
    output bbfb_pkg::t_job      o_job,
    output logic                o_job_valid,
    input  wire logic           i_job_take
);
    import bbfb_pkg::*;

    localparam int PP_W = (PACKET_BYTES > 2) ? $clog2(PACKET_BYTES) : 1;

    logic [PP_W-1:0]    r_pp, n_pp;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [7:0]         r_crc, n_crc;
    logic [7:0]         r_prev_crc, n_prev_crc;
    t_job               r_job, n_job;
    logic               r_job_valid;

    logic               w_acc;
    logic [FIELD_W-1:0] w_len;
    logic [PP_W:0]      w_rem;
    logic [7:0]         w_crc_new;
    logic               w_pkt_start;
    logic               w_pkt_end;

    assign o_ready     = !r_job_valid || i_job_take;
    assign w_acc       = i_valid && o_ready;
    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

    always_comb begin
        w_len       = (i_cfg.data_field_bytes == '0) ? FIELD_W'(1) : i_cfg.data_field_bytes;
        w_pkt_start = (r_pp == '0);
        w_pkt_end   = (r_pp == PP_W'(PACKET_BYTES - 1));
        w_rem       = (PP_W+1)'(PACKET_BYTES) - {1'b0, r_pp};

        n_job.first = (r_field == '0);
        n_job.data  = w_pkt_start ? r_prev_crc : i_byte;
        if (w_pkt_start) begin
            n_job.syncd = '0;
        end else if (FIELD_W'(w_rem) < w_len) begin
            n_job.syncd = 16'({w_rem, 3'b000});
        end else begin
            n_job.syncd = SYNCD_NONE;
        end

        w_crc_new = crc8_byte(w_pkt_start ? 8'h00 : r_crc, n_job.data);
        if (w_pkt_end) begin
            n_prev_crc = w_crc_new;
            n_crc      = '0;
            n_pp       = '0;
        end else begin
            n_prev_crc = r_prev_crc;
            n_crc      = w_crc_new;
            n_pp       = r_pp + PP_W'(1);
        end

        n_job.last = (({1'b0, r_field} + (FIELD_W+1)'(1)) >= {1'b0, w_len});
        n_field    = n_job.last ? '0 : r_field + FIELD_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp        <= '0;
            r_field     <= '0;
            r_crc       <= '0;
            r_prev_crc  <= FIRST_PKT_CRC;
            r_job_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_pp       <= n_pp;
                r_field    <= n_field;
                r_crc      <= n_crc;
                r_prev_crc <= n_prev_crc;
            end
            if (o_ready) begin
                r_job_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbfb_emit.sv =====
// ----------------------------------------------------------------------------
// bbfb_emit
// header generation, prbs scrambling and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbfb_emit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  bbfb_pkg::t_cfg  i_cfg,
    input  bbfb_pkg::t_job  i_job,
    input  wire logic       i_job_valid,
    output logic            o_job_take,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_frame_byte,
    output logic            o_is_header,
    output logic            o_frame_first,
    output logic            o_frame_last,
    output logic            o_run_last
);
    import bbfb_pkg::*;

    logic [HIDX_W-1:0]  r_hidx, n_hidx;
    logic [14:0]        r_prbs;
    logic [7:0]         r_hcrc, n_hcrc;
    logic               r_valid;
    logic [7:0]         r_byte;
    logic               r_hdr, r_first, r_last, r_rlast;

    logic               w_adv;
    logic               w_emit;
    logic               w_hdr;
    logic [FIELD_W-1:0] w_len;
    logic [15:0]        w_dfl;
    logic [7:0]         w_hbyte;
    logic [7:0]         w_byte;
    t_prbs_out          w_prbs;

    assign w_adv      = !r_valid || i_ready;
    assign w_emit     = w_adv && i_job_valid;
    assign w_hdr      = i_job.first && (r_hidx != H_DONE);
    assign o_job_take = w_emit && !w_hdr;

    always_comb begin
        w_len = (i_cfg.data_field_bytes == '0) ? FIELD_W'(1) : i_cfg.data_field_bytes;
        w_dfl = {w_len, 3'b000};
        case (r_hidx)
            H_MATYPE_HI: w_hbyte = i_cfg.mode_type_word[15:8];
            H_MATYPE_LO: w_hbyte = i_cfg.mode_type_word[7:0];
            H_UPL_HI:    w_hbyte = i_cfg.packet_length_bits[15:8];
            H_UPL_LO:    w_hbyte = i_cfg.packet_length_bits[7:0];
            H_DFL_HI:    w_hbyte = w_dfl[15:8];
            H_DFL_LO:    w_hbyte = w_dfl[7:0];
            H_SYNC:      w_hbyte = i_cfg.sync_byte_value;
            H_SYNCD_HI:  w_hbyte = i_job.syncd[15:8];
            H_SYNCD_LO:  w_hbyte = i_job.syncd[7:0];
            default:     w_hbyte = r_hcrc;
        endcase

        // prbs restarts on the first header byte of every frame
        w_prbs = prbs_byte((w_hdr && r_hidx == H_MATYPE_HI) ? PRBS_SEED : r_prbs);
        w_byte = (w_hdr ? w_hbyte : i_job.data)
               ^ (w_prbs.scr & {8{i_cfg.scramble_enable}});

        n_hcrc = crc8_byte((r_hidx == H_MATYPE_HI) ? 8'h00 : r_hcrc, w_hbyte);
        n_hidx = w_hdr ? r_hidx + HIDX_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx  <= '0;
            r_prbs  <= PRBS_SEED;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_hidx <= n_hidx;
                r_prbs <= w_prbs.state;
            end
            if (w_adv) begin
                r_valid <= i_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte  <= w_byte;
            r_hdr   <= w_hdr;
            r_first <= w_hdr && (r_hidx == H_MATYPE_HI);
            r_last  <= !w_hdr && i_job.last;
            r_rlast <= !w_hdr;
            if (w_hdr && r_hidx != H_CRC) begin
                r_hcrc <= n_hcrc;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_byte  = r_byte;
    assign o_is_header   = r_hdr;
    assign o_frame_first = r_first;
    assign o_frame_last  = r_last;
    assign o_run_last    = r_rlast;

endmodule

`default_nettype wire

// ===== hw/rtl/baseband_frame_builder.sv =====
// path: an accepted stream byte passes the front job register and then the emit output
//   register; when the byte opens a frame, the ten header bytes go out first
// throughput: one output byte per cycle from the output register while i_ready is high;
//   a frame-opening byte holds the input until its header bytes have been sent
// reset: synchronous active low; clears packet, field, crc and prbs state and
//   loads the register defaults; pready is always high
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// baseband_frame_builder
// packs 188-byte stream packets into scrambled baseband frames with header
// ----------------------------------------------------------------------------
module baseband_frame_builder #(
    parameter int PACKET_BYTES = 188
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // stream input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_stream_byte,
    // frame output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_frame_byte,
    output logic             o_is_header,
    output logic             o_frame_first,
    output logic             o_frame_last,
    output logic             o_run_last
);
    import bbfb_pkg::*;

    t_cfg w_cfg;
    t_job w_job;
    logic w_job_valid;
    logic w_job_take;

    assign pready = 1'b1;

    // register file, written on the access phase of an apb transaction
    bbfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // input register stage: sync byte replacement, packet crc, syncd, frame position
    bbfb_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_valid),
        .i_byte      (i_stream_byte),
        .o_ready     (o_ready),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take)
    );

    // result register stage: header bytes, header crc, prbs scrambling
    bbfb_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_job         (w_job),
        .i_job_valid   (w_job_valid),
        .o_job_take    (w_job_take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_byte  (o_frame_byte),
        .o_is_header   (o_is_header),
        .o_frame_first (o_frame_first),
        .o_frame_last  (o_frame_last),
        .o_run_last    (o_run_last)
    );

    // a frame start is always a header byte and never the end of a run
    `ASSERT_IMPLY(a_first_is_header, i_clk, i_rst_n,
        o_valid && o_frame_first, o_is_header && !o_run_last && !o_frame_last)
    // frame end only on the data byte of a run
    `ASSERT_IMPLY(a_last_on_data, i_clk, i_rst_n,
        o_valid && o_frame_last, o_run_last && !o_is_header)
    // header bytes are followed without a gap by the rest of the run
    `ASSERT_NEXT(a_header_run_continues, i_clk, i_rst_n,
        o_valid && i_ready && o_is_header, o_valid && !o_frame_first)

endmodule

`default_nettype wire
